[rtl/core/congestion_window_and_rto_control_assert.svh]
// Assertion macros shared by the congestion window and timeout controller.
`ifndef CONGESTION_WINDOW_AND_RTO_CONTROL_ASSERT_SVH
`define CONGESTION_WINDOW_AND_RTO_CONTROL_ASSERT_SVH

// check a condition at every clock edge outside reset
`define CWRTO_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// check that a condition on one edge implies another on the next edge
`define CWRTO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cwrto_pkg.sv]
// Package with request and result types and constants of the congestion controller.
`timescale 1ns / 1ps
`default_nettype none

package cwrto_pkg;

  localparam int WIN_W     = 7;
  localparam int TIME_W    = 32;
  localparam int SEQ_W     = 32;
  localparam int SIZE_W    = 16;
  localparam int RETX_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [WIN_W-1:0]  WINDOW_MAX        = 7'd64;
  localparam logic [WIN_W-1:0]  THRESHOLD_RESET   = 7'd64;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET     = 32'd1000000;

  localparam logic [1:0] OP_ACK     = 2'd0;
  localparam logic [1:0] OP_RTT     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TIMEOUT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_THRESHOLD = 1'd1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [SEQ_W-1:0]  seq_start;
    logic [SIZE_W-1:0] payload_size;
    logic [SEQ_W-1:0]  ack_number;
    logic [TIME_W-1:0] elapsed_us;
    logic [RETX_W-1:0] retx_count;
    logic [RETX_W-1:0] ack_retx_count;
  } req_t;

  typedef struct packed {
    logic [WIN_W-1:0]  window_now;
    logic [WIN_W-1:0]  threshold_now;
    logic [TIME_W-1:0] timeout_now;
    logic              retransmit;
    logic              ack_mismatch;
  } rsp_t;

endpackage

`default_nettype wire

[rtl/core/congestion_window_and_rto_control.sv]
// Congestion window and retransmission timeout controller, top level.
// A request is captured in the request register and its result in the result register; a stalled
// output holds both. Throughput: one request per cycle while the output is not stalled; the state
// update through the rtt multiply-add is combinational between the request and result registers.
// Reset: window 1, threshold 64, timeout 1000000 us, estimate and deviation 0,
// request and result registers empty.
`timescale 1ns / 1ps
`default_nettype none
`include "congestion_window_and_rto_control_assert.svh"

module congestion_window_and_rto_control (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire cwrto_pkg::req_t                     in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output cwrto_pkg::rsp_t                          out_data,
  input  wire logic                                cfg_we,
  input  wire logic [cwrto_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cwrto_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic                             req_valid;
  cwrto_pkg::req_t                  req;
  logic                             advance;

  logic [cwrto_pkg::WIN_W-1:0]      window_size, window_size_next;
  logic [cwrto_pkg::WIN_W-1:0]      threshold, threshold_next;
  logic [cwrto_pkg::WIN_W-1:0]      ack_count, ack_count_next;
  logic [cwrto_pkg::TIME_W-1:0]     rtt_estimate, rtt_estimate_next;
  logic [cwrto_pkg::TIME_W-1:0]     rtt_deviation, rtt_deviation_next;
  logic [cwrto_pkg::TIME_W-1:0]     retx_timeout, retx_timeout_next;
  logic                             retransmit_next, mismatch_next;

  logic [cwrto_pkg::WIN_W-1:0]      ack_count_inc;
  logic [cwrto_pkg::SEQ_W-1:0]      seq_end;
  logic [cwrto_pkg::RETX_W-1:0]     retx_diff;
  logic [47:0]                      product;
  logic [48:0]                      sample_sum;
  logic [31:0]                      sample;
  logic [34:0]                      est_x7;
  logic [32:0]                      est_sum;
  logic [31:0]                      est_new;
  logic [32:0]                      gap_wide;
  logic [31:0]                      gap;
  logic [33:0]                      dev_x3;
  logic [32:0]                      dev_sum;
  logic [31:0]                      dev_new;
  logic [34:0]                      tmo_sum;
  logic [31:0]                      tmo_new;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  // rtt sample and smoothing
  assign seq_end    = req.seq_start + {16'd0, req.payload_size};
  assign retx_diff  = (req.retx_count > req.ack_retx_count) ?
                      (req.retx_count - req.ack_retx_count) : '0;
  assign product    = retx_diff * retx_timeout;
  assign sample_sum = {17'd0, req.elapsed_us} + {1'b0, product};
  assign sample     = (|sample_sum[48:32]) ? '1 : sample_sum[31:0];

  assign est_x7  = {rtt_estimate, 3'b000} - {3'b000, rtt_estimate};
  assign est_sum = {1'b0, est_x7[34:3]} + {4'd0, sample[31:3]};
  assign est_new = est_sum[32] ? '1 : est_sum[31:0];

  assign gap_wide = ({1'b0, sample} >= est_sum) ? ({1'b0, sample} - est_sum)
                                                : (est_sum - {1'b0, sample});
  assign gap      = gap_wide[31:0];

  assign dev_x3  = {1'b0, rtt_deviation, 1'b0} + {2'b00, rtt_deviation};
  assign dev_sum = {1'b0, dev_x3[33:2]} + {3'd0, gap[31:2]};
  assign dev_new = dev_sum[32] ? '1 : dev_sum[31:0];

  assign tmo_sum = {3'd0, est_new} + {1'b0, dev_new, 2'b00};
  assign tmo_new = (|tmo_sum[34:32]) ? '1 : tmo_sum[31:0];

  assign ack_count_inc = ack_count + 7'd1;

  always_comb begin
    window_size_next   = window_size;
    threshold_next     = threshold;
    ack_count_next     = ack_count;
    rtt_estimate_next  = rtt_estimate;
    rtt_deviation_next = rtt_deviation;
    retx_timeout_next  = retx_timeout;
    retransmit_next    = 1'b0;
    mismatch_next      = 1'b0;
    case (req.opcode)
      cwrto_pkg::OP_ACK: begin
        if (window_size < cwrto_pkg::WINDOW_MAX) begin
          if (window_size < threshold) begin
            window_size_next = window_size + 7'd1;
          end else if (ack_count_inc >= window_size) begin
            window_size_next = window_size + 7'd1;
            ack_count_next   = '0;
          end else begin
            ack_count_next = ack_count_inc;
          end
        end
      end
      cwrto_pkg::OP_RTT: begin
        if (seq_end != req.ack_number) begin
          mismatch_next = 1'b1;
        end else begin
          rtt_estimate_next  = est_new;
          rtt_deviation_next = dev_new;
          retx_timeout_next  = tmo_new;
        end
      end
      cwrto_pkg::OP_TIMEOUT: begin
        if (req.elapsed_us >= retx_timeout) begin
          retransmit_next  = 1'b1;
          threshold_next   = (window_size <= 7'd1) ? 7'd1 : {1'b0, window_size[6:1]};
          window_size_next = 7'd1;
          ack_count_next   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid     <= 1'b0;
      out_valid     <= 1'b0;
      window_size   <= 7'd1;
      threshold     <= cwrto_pkg::THRESHOLD_RESET;
      ack_count     <= '0;
      rtt_estimate  <= '0;
      rtt_deviation <= '0;
      retx_timeout  <= cwrto_pkg::TIMEOUT_RESET;
    end else begin
      if (in_ready) begin
        req_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        window_size   <= window_size_next;
        threshold     <= threshold_next;
        ack_count     <= ack_count_next;
        rtt_estimate  <= rtt_estimate_next;
        rtt_deviation <= rtt_deviation_next;
        retx_timeout  <= retx_timeout_next;
      end else if (cfg_we) begin
        case (cfg_index)
          cwrto_pkg::CFG_INITIAL_TIMEOUT:   retx_timeout <= cfg_data;
          cwrto_pkg::CFG_INITIAL_THRESHOLD: threshold    <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  // hold payloads until they move on
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    if (advance) begin
      out_data.window_now    <= window_size_next;
      out_data.threshold_now <= threshold_next;
      out_data.timeout_now   <= retx_timeout_next;
      out_data.retransmit    <= retransmit_next;
      out_data.ack_mismatch  <= mismatch_next;
    end
  end

  `CWRTO_ASSERT(a_count_below_window, ack_count < window_size,
    "avoidance ack count reached the window")
  `CWRTO_ASSERT(a_window_range,
    (window_size >= 7'd1) && (window_size <= cwrto_pkg::WINDOW_MAX),
    "window outside its range")
  `CWRTO_ASSERT(a_flags_exclusive,
    !(out_valid && out_data.retransmit && out_data.ack_mismatch),
    "retransmit and mismatch in one result")
  `CWRTO_ASSERT(a_retransmit_collapses,
    !(out_valid && out_data.retransmit) || (out_data.window_now == 7'd1),
    "retransmit without window collapse")
  `CWRTO_ASSERT_NEXT(a_state_holds, !advance && !cfg_we,
    $stable(window_size) && $stable(retx_timeout) && $stable(threshold),
    "state changed without a request or write")
  `CWRTO_ASSERT_NEXT(a_stall_keeps_request, req_valid && out_valid && !out_ready,
    req_valid, "request dropped while result stalled")

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for congestion_window_and_rto_control, with a cycle-free predictor.
module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_PCT = 11;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_COUNT = 10;
  localparam int PHASE_REQS = 175;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cwrto_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cwrto_pkg::rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [cwrto_pkg::CFG_IDX_W-1:0] cfg_index = cwrto_pkg::CFG_INITIAL_TIMEOUT;
  logic [cwrto_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic steady = 1'b0;

  cwrto_pkg::req_t pending_reqs[$];
  cwrto_pkg::rsp_t expected_rsps[$];
  cwrto_pkg::rsp_t want_rsp;
  int mismatches = 0;
  int quiet_cycles = 0;

  logic [cwrto_pkg::WIN_W-1:0] win_q = 7'd1;
  logic [cwrto_pkg::WIN_W-1:0] thresh_q = cwrto_pkg::THRESHOLD_RESET;
  logic [cwrto_pkg::WIN_W-1:0] ack_tally = '0;
  logic [cwrto_pkg::TIME_W-1:0] srtt = '0;
  logic [cwrto_pkg::TIME_W-1:0] rttvar = '0;
  logic [cwrto_pkg::TIME_W-1:0] rto_q = cwrto_pkg::TIMEOUT_RESET;

  congestion_window_and_rto_control dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [cwrto_pkg::TIME_W-1:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? '1 : v[cwrto_pkg::TIME_W-1:0];
  endfunction

  function automatic cwrto_pkg::rsp_t advance_controller(cwrto_pkg::req_t r);
    cwrto_pkg::rsp_t res;
    logic [cwrto_pkg::SEQ_W-1:0] seq_end;
    logic [63:0] diff, sample, est, dev, gap;
    res = '0;
    case (r.opcode)
      cwrto_pkg::OP_ACK: begin
        if (win_q < cwrto_pkg::WINDOW_MAX) begin
          if (win_q < thresh_q) begin
            win_q = win_q + 7'd1;
          end else begin
            ack_tally = ack_tally + 7'd1;
            if (ack_tally >= win_q) begin
              win_q = win_q + 7'd1;
              ack_tally = '0;
            end
          end
        end
      end
      cwrto_pkg::OP_RTT: begin
        seq_end = r.seq_start + {16'd0, r.payload_size};
        if (seq_end != r.ack_number) begin
          res.ack_mismatch = 1'b1;
        end else begin
          diff = (r.retx_count > r.ack_retx_count) ?
                 64'(r.retx_count - r.ack_retx_count) : 64'd0;
          sample = 64'(sat32(64'(r.elapsed_us) + diff * 64'(rto_q)));
          est = ((64'd7 * 64'(srtt)) >> 3) + (sample >> 3);
          gap = (sample >= est) ? sample - est : est - sample;
          dev = ((64'd3 * 64'(rttvar)) >> 2) + (gap >> 2);
          srtt = sat32(est);
          rttvar = sat32(dev);
          rto_q = sat32(64'(srtt) + 64'd4 * 64'(rttvar));
        end
      end
      cwrto_pkg::OP_TIMEOUT: begin
        if (r.elapsed_us >= rto_q) begin
          res.retransmit = 1'b1;
          thresh_q = (win_q <= 7'd1) ? 7'd1 : (win_q >> 1);
          win_q = 7'd1;
          ack_tally = '0;
        end
      end
      default: ;
    endcase
    res.window_now = win_q;
    res.threshold_now = thresh_q;
    res.timeout_now = rto_q;
    return res;
  endfunction

  function automatic cwrto_pkg::req_t build_req(logic [1:0] op,
      logic [cwrto_pkg::SEQ_W-1:0] seq, logic [cwrto_pkg::SIZE_W-1:0] size,
      logic [cwrto_pkg::SEQ_W-1:0] ack, logic [cwrto_pkg::TIME_W-1:0] elapsed,
      logic [cwrto_pkg::RETX_W-1:0] retx, logic [cwrto_pkg::RETX_W-1:0] ack_retx);
    cwrto_pkg::req_t r;
    r.opcode = op;
    r.seq_start = seq;
    r.payload_size = size;
    r.ack_number = ack;
    r.elapsed_us = elapsed;
    r.retx_count = retx;
    r.ack_retx_count = ack_retx;
    return r;
  endfunction

  task automatic write_reg(input logic [cwrto_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cwrto_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cwrto_pkg::CFG_INITIAL_TIMEOUT) begin
      rto_q = value;
    end else begin
      thresh_q = value[cwrto_pkg::WIN_W-1:0];
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
  endtask

  initial begin
    int ph, n, pick;
    bit grow;
    cwrto_pkg::req_t r;
    logic [cwrto_pkg::CFG_DATA_W-1:0] tmo_val, thr_val;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    pending_reqs.push_back(build_req(cwrto_pkg::OP_ACK, '0, '0, '0, '0, '0, '0));
    pending_reqs.push_back(build_req(cwrto_pkg::OP_RTT, '1, 16'd1, '0, 32'd1000, 16'd0,
                                     16'd5));
    pending_reqs.push_back(build_req(cwrto_pkg::OP_RTT, '0, '1, '0, '1, '1, '0));
    pending_reqs.push_back(build_req(cwrto_pkg::OP_TIMEOUT, '0, '0, '0, '0, '0, '0));
    pending_reqs.push_back(build_req(cwrto_pkg::OP_TIMEOUT, '0, '0, '0, 32'd997, '0, '0));
    pending_reqs.push_back(build_req(cwrto_pkg::OP_TIMEOUT, '0, '0, '0, '1, '0, '0));
    repeat (3) pending_reqs.push_back(build_req(cwrto_pkg::OP_ACK, '0, '0, '0, '0, '0, '0));
    pending_reqs.push_back(build_req(OP_UNUSED, '1, '1, '1, '1, '1, '1));
    repeat (2) pending_reqs.push_back(build_req(cwrto_pkg::OP_RTT, '1, '1, 32'h0000_FFFE,
                                                '1, '1, '0));
    pending_reqs.push_back(build_req(cwrto_pkg::OP_TIMEOUT, '0, '0, '0, 32'hFFFF_FFFE,
                                     '0, '0));
    pending_reqs.push_back(build_req(cwrto_pkg::OP_TIMEOUT, '0, '0, '0, '1, '0, '0));
    pending_reqs.push_back(build_req(cwrto_pkg::OP_RTT, 32'h8000_0000, '0, 32'h8000_0000,
                                     '0, '0, '0));

    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      drain();
      case (ph)
        0: begin tmo_val = '1; thr_val = 32'd127; end
        1: begin tmo_val = 32'd1; thr_val = 32'd0; end
        2: begin tmo_val = 32'd200000; thr_val = 32'd64; end
        3: begin tmo_val = 32'd0; thr_val = 32'd1; end
        4: begin tmo_val = 32'd1000000; thr_val = 32'd0; end
        5: begin tmo_val = $urandom(); thr_val = $urandom_range(64, 1); end
        6: begin tmo_val = '1; thr_val = 32'd127; end
        7: begin tmo_val = $urandom_range(400000); thr_val = $urandom_range(127); end
        8: begin tmo_val = 32'd1; thr_val = 32'd3; end
        default: begin tmo_val = $urandom(); thr_val = $urandom(); end
      endcase
      write_reg(cwrto_pkg::CFG_INITIAL_TIMEOUT, tmo_val);
      write_reg(cwrto_pkg::CFG_INITIAL_THRESHOLD, thr_val);
      steady <= (ph == 3);
      grow = (ph % 2 == 0);
      for (n = 0; n < PHASE_REQS; n++) begin
        pick = $urandom_range(99);
        if (grow) begin
          r.opcode = (pick < 88) ? cwrto_pkg::OP_ACK :
                     (pick < 96) ? cwrto_pkg::OP_RTT : OP_UNUSED;
        end else begin
          r.opcode = (pick < 55) ? cwrto_pkg::OP_ACK : (pick < 80) ? cwrto_pkg::OP_RTT :
                     (pick < 95) ? cwrto_pkg::OP_TIMEOUT : OP_UNUSED;
        end
        r.seq_start = $urandom();
        r.payload_size = 16'($urandom());
        pick = $urandom_range(99);
        if (pick < 80) begin
          r.ack_number = r.seq_start + {16'd0, r.payload_size};
        end else if (pick < 90) begin
          r.ack_number = r.seq_start + {16'd0, r.payload_size} +
                         ($urandom_range(1) ? 32'd1 : '1);
        end else begin
          r.ack_number = $urandom();
        end
        pick = $urandom_range(19);
        if (pick == 0) begin
          r.elapsed_us = '0;
        end else if (pick == 1) begin
          r.elapsed_us = '1;
        end else if (pick < 4) begin
          r.elapsed_us = $urandom();
        end else begin
          r.elapsed_us = $urandom_range((r.opcode == cwrto_pkg::OP_TIMEOUT) ? 600000 : 250000);
        end
        r.retx_count = 16'($urandom());
        pick = $urandom_range(19);
        if (pick < 17) begin
          r.ack_retx_count = r.retx_count;
        end else if (pick < 19) begin
          r.ack_retx_count = 16'($urandom_range(3));
          r.retx_count = r.ack_retx_count + 16'($urandom_range(2));
        end else begin
          r.ack_retx_count = 16'($urandom());
        end
        pending_reqs.push_back(r);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hold each request until accepted, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(advance_controller(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= STALL_PCT)) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: win %0d thr %0d rto %0d rtx %b mis %b",
                     out_data.window_now, out_data.threshold_now, out_data.timeout_now,
                     out_data.retransmit, out_data.ack_mismatch);
          end
        end else begin
          want_rsp = expected_rsps.pop_front();
          if (out_data.window_now !== want_rsp.window_now ||
              out_data.threshold_now !== want_rsp.threshold_now ||
              out_data.timeout_now !== want_rsp.timeout_now ||
              out_data.retransmit !== want_rsp.retransmit ||
              out_data.ack_mismatch !== want_rsp.ack_mismatch) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected win %0d thr %0d rto %0d rtx %b mis %b",
                       want_rsp.window_now, want_rsp.threshold_now, want_rsp.timeout_now,
                       want_rsp.retransmit, want_rsp.ack_mismatch);
              $display("          actual   win %0d thr %0d rto %0d rtx %b mis %b",
                       out_data.window_now, out_data.threshold_now, out_data.timeout_now,
                       out_data.retransmit, out_data.ack_mismatch);
            end
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= STALL_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/cwrto_pkg.sv
rtl/core/congestion_window_and_rto_control.sv
verif/tb.sv
